/* hdl/cdrcb_pkg.sv */
`timescale 1ns / 1ps
// Package for the CD-ROM read command builder: word types, status and op codes,
// register indexes and command opcodes. Used by cdrcb_engine and the top level.
// No dependencies.
package cdrcb_pkg;

    // Operation codes of an input word.
    localparam logic [1:0] OP_REQUEST    = 2'd0;
    localparam logic [1:0] OP_COMPLETION = 2'd1;
    localparam logic [1:0] OP_QUERY      = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_FAIL   = 3'd1;
    localparam logic [2:0] ST_HIT    = 3'd2;
    localparam logic [2:0] ST_ISSUED = 3'd3;
    localparam logic [2:0] ST_RETRY  = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_DEVICE_COUNT = 1'b0;
    localparam logic CFG_UNIT_NUMBER  = 1'b1;

    // Command opcodes and sense codes.
    localparam logic [7:0] OPC_READ6       = 8'h08;
    localparam logic [7:0] OPC_READ10      = 8'h28;
    localparam logic [6:0] SENSE_FIXED     = 7'h70;
    localparam logic [3:0] KEY_UNIT_ATTN   = 4'h6;
    localparam logic [7:0] KEY_ILLEGAL_REQ = 8'h05;
    localparam logic [7:0] KEY_NOT_READY   = 8'h02;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  device;
        logic        is_write;
        logic [31:0] sector;
        logic [19:0] sector_count;
        logic        any_error;
        logic        driver_error;
        logic [7:0]  sense_first;
        logic [7:0]  sense_key_byte;
        logic        test_failed;
        logic        keep_changed;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic        cdb_is_ten;
        logic [63:0] cdb_head;
        logic [15:0] cdb_tail;
        logic [15:0] block_count;
        logic [19:0] sectors_taken;
        logic [1:0]  buffer_offset;
        logic        use_buffer;
        logic        changed_flag;
    } t_out_word;

    // Per-drive state changes requested by the engine for one word.
    typedef struct packed {
        logic tag_wr;
        logic tag_clr;
        logic disc_set;
        logic disc_clr;
        logic ten_clr;
    } t_upd;

endpackage

/* hdl/cdrcb_engine.sv */
`timescale 1ns / 1ps
// Decision logic for one word: request split, buffer check, command block packing,
// sense classification and media query. Depends on cdrcb_pkg.
module cdrcb_engine (
    input  cdrcb_pkg::t_in_word  i_word,
    input  logic                 i_dev_ok,
    input  logic [31:0]          i_tag,
    input  logic                 i_disc,
    input  logic                 i_ten_ok,
    input  logic [2:0]           i_unit,
    output cdrcb_pkg::t_out_word o_res,
    output cdrcb_pkg::t_upd      o_upd
);
    import cdrcb_pkg::*;

    logic [1:0]  start;
    logic [29:0] block;
    logic        buffered;
    logic [2:0]  off_lim;
    logic [19:0] cnt;
    logic [18:0] blocks_raw;
    logic [15:0] blocks;
    logic [19:0] taken;
    logic        ten;
    logic [7:0]  cmd1;
    logic        unit_attn;

    assign start     = i_word.sector[1:0];
    assign block     = i_word.sector[31:2];
    assign buffered  = (start != 2'd0) || (i_word.sector_count < 20'd4);
    assign off_lim   = 3'd4 - {1'b0, start};
    assign cmd1      = {i_unit, 5'd0};
    assign unit_attn = (i_word.sense_first[6:0] == SENSE_FIXED)
                    && (i_word.sense_key_byte[3:0] == KEY_UNIT_ATTN);

    // Sector count after the buffer split or rounding.
    always_comb begin
        if (buffered) begin
            if ((start != 2'd0) && (i_word.sector_count > 20'(off_lim))) begin
                cnt = 20'(off_lim);
            end else begin
                cnt = i_word.sector_count;
            end
        end else begin
            cnt = {i_word.sector_count[19:2], 2'b00};
        end
    end

    assign blocks_raw = 19'((21'(cnt) + 21'd3) >> 2);
    assign ten = ((blocks_raw > 19'h000ff) || (block > 30'h1fffff)) && i_ten_ok;

    // Clamp to the count field of the chosen command form.
    always_comb begin
        if (ten) begin
            if (blocks_raw > 19'h0ffff) begin
                blocks = 16'hffff;
                taken  = 20'h3fffc;
            end else begin
                blocks = blocks_raw[15:0];
                taken  = cnt;
            end
        end else begin
            if (blocks_raw > 19'h000ff) begin
                blocks = 16'h00ff;
                taken  = 20'h003fc;
            end else begin
                blocks = blocks_raw[15:0];
                taken  = cnt;
            end
        end
    end

    always_comb begin
        o_res = '0;
        o_upd = '0;
        case (i_word.op)
            OP_REQUEST: begin
                if (i_word.is_write || !i_dev_ok || i_disc) begin
                    o_res.status = ST_FAIL;
                end else if (buffered && (i_tag == {2'b00, block})) begin
                    o_res.status        = ST_HIT;
                    o_res.buffer_offset = start;
                    o_res.use_buffer    = 1'b1;
                    o_res.sectors_taken = cnt;
                end else begin
                    o_upd.tag_wr        = buffered;
                    o_res.status        = ST_ISSUED;
                    o_res.buffer_offset = buffered ? start : 2'd0;
                    o_res.use_buffer    = buffered;
                    o_res.cdb_is_ten    = ten;
                    o_res.block_count   = blocks;
                    o_res.sectors_taken = taken;
                    if (ten) begin
                        o_res.cdb_head = {OPC_READ10, cmd1, 2'b00, block, 8'h00,
                                          blocks[15:8]};
                        o_res.cdb_tail = {blocks[7:0], 8'h00};
                    end else begin
                        o_res.cdb_head = {OPC_READ6, cmd1[7:5], block[20:16], block[15:8],
                                          block[7:0], blocks[7:0], 24'd0};
                    end
                end
            end
            OP_COMPLETION: begin
                o_res.status = (i_word.any_error || i_word.driver_error) ? ST_FAIL : ST_OK;
                if (i_dev_ok) begin
                    o_res.status = i_word.any_error ? ST_FAIL : ST_OK;
                    if (i_word.driver_error) begin
                        o_upd.tag_clr = 1'b1;
                        if (unit_attn) begin
                            o_upd.disc_set = 1'b1;
                            o_res.status   = ST_FAIL;
                        end else if (i_word.sense_key_byte == KEY_ILLEGAL_REQ) begin
                            o_upd.ten_clr = i_ten_ok;
                            o_res.status  = i_ten_ok ? ST_RETRY : ST_FAIL;
                        end else if (i_word.sense_key_byte == KEY_NOT_READY) begin
                            o_res.status = ST_FAIL;
                        end
                    end
                end
            end
            OP_QUERY: begin
                o_res.status = ST_OK;
                if (i_dev_ok) begin
                    if (i_word.test_failed) begin
                        o_upd.disc_set     = 1'b1;
                        o_res.changed_flag = 1'b1;
                    end else begin
                        o_res.changed_flag = i_disc;
                        o_upd.disc_clr     = !i_word.keep_changed;
                    end
                end
            end
            default: begin
                o_res.status = ST_FAIL;
            end
        endcase
    end

endmodule

/* hdl/cdrom_read_command_builder.sv */
`timescale 1ns / 1ps
// Top level of the CD-ROM read command builder: handshakes, configuration registers,
// per-drive state and the buffer tag memory. Depends on cdrcb_pkg and cdrcb_engine.
//
// Usage:
//   Input channel i_in_valid / o_in_ready carries one t_in_word per word: a block
//   request, a command completion or a media query for one drive. Output channel
//   o_out_valid / i_out_ready returns exactly one t_out_word for each input word,
//   in order. Configuration is written through i_cfg_wr_en / i_cfg_idx /
//   i_cfg_wdata (drive count, logical unit) while the block is idle.
//   After acceptance the word is registered with its drive's buffer tag read from the
//   tag memory, then decided and packed into the result register. Throughput is one
//   word per cycle while the receiver keeps i_out_ready high.
//   When the receiver stalls, the result register holds its word and the input
//   register holds the next one; o_in_ready falls until the result is taken.
//   Drive state is updated only when a word moves into the result register.
//   Reset clears the configuration to zero, marks every drive as holding no
//   buffered block, clears the changed bits and allows ten-byte commands; no
//   clearing pass is needed, so words are taken right after reset.
module cdrom_read_command_builder #(
    parameter int unsigned MAX_DEVICES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  cdrcb_pkg::t_in_word  i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output cdrcb_pkg::t_out_word o_out_word,
    input  logic                 i_cfg_wr_en,
    input  logic                 i_cfg_idx,
    input  logic [3:0]           i_cfg_wdata
);
    import cdrcb_pkg::*;

    localparam int unsigned DEV_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;

    logic [3:0]             r_dev_cnt;
    logic [2:0]             r_unit;
    t_in_word               r_in;
    logic                   r_in_valid;
    logic [31:0]            r_tag_rd;
    t_out_word              r_out;
    logic                   r_out_valid;
    logic [MAX_DEVICES-1:0] r_tag_vld;
    logic [MAX_DEVICES-1:0] r_disc;
    logic [MAX_DEVICES-1:0] r_ten;
    logic [31:0]            r_tag_mem [MAX_DEVICES];

    logic             w_adv;
    logic             w_dev_ok;
    logic [DEV_W-1:0] w_idx;
    logic [DEV_W-1:0] w_rd_idx;
    logic [31:0]      w_tag_wdata;
    logic [31:0]      w_tag;
    logic             w_disc;
    logic             w_ten_ok;
    logic             w_tag_wr;
    t_out_word        w_res;
    t_upd             w_upd;

    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;
    assign w_idx      = r_in.device[DEV_W-1:0];
    assign w_rd_idx   = i_in_word.device[DEV_W-1:0];
    assign w_dev_ok   = (r_in.device < {4'd0, r_dev_cnt})
                     && (32'(r_in.device) < MAX_DEVICES);

    // A drive with no block held reads as all ones, which never matches a block.
    assign w_tag       = (w_dev_ok && r_tag_vld[w_idx]) ? r_tag_rd : 32'hffff_ffff;
    assign w_disc      = w_dev_ok && r_disc[w_idx];
    assign w_ten_ok    = w_dev_ok && r_ten[w_idx];
    assign w_tag_wdata = {2'b00, r_in.sector[31:2]};
    assign w_tag_wr    = w_adv && w_upd.tag_wr;

    cdrcb_engine u_engine (
        .i_word   (r_in),
        .i_dev_ok (w_dev_ok),
        .i_tag    (w_tag),
        .i_disc   (w_disc),
        .i_ten_ok (w_ten_ok),
        .i_unit   (r_unit),
        .o_res    (w_res),
        .o_upd    (w_upd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_cnt <= 4'd0;
            r_unit    <= 3'd0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_DEVICE_COUNT: r_dev_cnt <= i_cfg_wdata;
                CFG_UNIT_NUMBER:  r_unit    <= i_cfg_wdata[2:0];
                default:          r_unit    <= r_unit;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_word;
        end
    end

    // Tag memory: one write port, one registered read port. A write to the
    // drive being read in the same cycle is forwarded.
    always_ff @(posedge i_clk) begin
        if (w_tag_wr) begin
            r_tag_mem[w_idx] <= w_tag_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            if (w_tag_wr && (w_idx == w_rd_idx)) begin
                r_tag_rd <= w_tag_wdata;
            end else begin
                r_tag_rd <= r_tag_mem[w_rd_idx];
            end
        end
    end

    // Per-drive flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_vld <= '0;
            r_disc    <= '0;
            r_ten     <= '1;
        end else if (w_adv && w_dev_ok) begin
            if (w_upd.tag_wr) begin
                r_tag_vld[w_idx] <= 1'b1;
            end else if (w_upd.tag_clr) begin
                r_tag_vld[w_idx] <= 1'b0;
            end
            if (w_upd.disc_set) begin
                r_disc[w_idx] <= 1'b1;
            end else if (w_upd.disc_clr) begin
                r_disc[w_idx] <= 1'b0;
            end
            if (w_upd.ten_clr) begin
                r_ten[w_idx] <= 1'b0;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_hit_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.status == ST_HIT))
            |-> (o_out_word.use_buffer && (o_out_word.block_count == 16'd0)))
        else $error("buffer hit carries a block count or no buffer flag");

    a_ten_only_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.cdb_is_ten) |-> (o_out_word.status == ST_ISSUED))
        else $error("ten-byte flag on a result that issued no command");

    a_six_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.status == ST_ISSUED) && !o_out_word.cdb_is_ten)
            |-> (o_out_word.block_count <= 16'h00ff))
        else $error("six-byte command with a block count above its field");

    a_tag_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tag_wr && w_dev_ok) |=> r_tag_vld[$past(w_idx)])
        else $error("buffer tag written but drive still shows no block held");

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for cdrom_read_command_builder: random and directed request,
// completion and query words, checked against a per-drive model of tags and flags.
// Depends on cdrcb_pkg and the RTL under hdl.
module tb;
    import cdrcb_pkg::*;

    localparam int unsigned NUM_DRIVES   = 8;
    localparam logic [1:0]  OP_UNDEFINED = 2'd3;
    localparam int unsigned LONG_HOLD    = 150;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_word  in_word = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_word;
    logic      cfg_wr_en = 1'b0;
    logic      cfg_idx = 1'b0;
    logic [3:0] cfg_wdata = 4'd0;

    cdrom_read_command_builder #(
        .MAX_DEVICES(NUM_DRIVES)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_word (out_word),
        .i_cfg_wr_en(cfg_wr_en),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_wdata(cfg_wdata)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Model of the per-drive state and the two registers.
    logic [31:0] drive_tag     [NUM_DRIVES];
    logic        drive_changed [NUM_DRIVES];
    logic        drive_ten_ok  [NUM_DRIVES];
    logic [3:0]  cfg_drives = 4'd0;
    logic [2:0]  cfg_lun = 3'd0;

    t_in_word    pending_words[$];
    t_out_word   replies_due[$];
    int unsigned mismatches = 0;

    // Stimulus-side bookkeeping.
    logic [31:0] recent_sector [NUM_DRIVES];
    int unsigned phase_drives = 0;

    // Handshake bookkeeping shared between the edge processes of each side.
    logic        in_took = 1'b0;
    logic        feeding = 1'b0;
    int unsigned send_wait = 0;
    int unsigned send_mode = 1;
    int unsigned send_count = 0;
    logic        out_took = 1'b0;
    int unsigned recv_wait = 0;
    int unsigned recv_mode = 1;
    int unsigned results_seen = 0;
    int unsigned next_hold = 200;

    function automatic t_out_word decide_reply(input t_in_word w);
        t_out_word   r;
        logic [31:0] blk;
        logic [19:0] sects;
        logic [31:0] nblk;
        logic        known;
        logic        hit;
        int unsigned d;
        r = '0;
        d = 32'(w.device);
        known = (d < cfg_drives) && (d < NUM_DRIVES);
        case (w.op)
            OP_REQUEST: begin
                blk = {2'b00, w.sector[31:2]};
                sects = w.sector_count;
                hit = 1'b0;
                if (w.is_write || !known || drive_changed[d]) begin
                    r.status = ST_FAIL;
                end else begin
                    // Partial blocks go through the one-block buffer.
                    if (w.sector[1:0] != 2'd0 || sects < 20'd4) begin
                        if (w.sector[1:0] != 2'd0 && sects > 20'd4 - w.sector[1:0]) begin
                            sects = 20'd4 - w.sector[1:0];
                        end
                        r.use_buffer = 1'b1;
                        r.buffer_offset = w.sector[1:0];
                        if (drive_tag[d] == blk) begin
                            hit = 1'b1;
                            r.status = ST_HIT;
                            r.sectors_taken = sects;
                        end else begin
                            drive_tag[d] = blk;
                        end
                    end else begin
                        sects[1:0] = 2'b00;
                    end
                    if (!hit) begin
                        nblk = ({12'd0, sects} + 32'd3) >> 2;
                        if ((nblk > 32'hff || blk > 32'h1fffff) && drive_ten_ok[d]) begin
                            if (nblk > 32'hffff) begin
                                nblk = 32'hffff;
                                sects = {nblk[17:0], 2'b00};
                            end
                            r.cdb_is_ten = 1'b1;
                            r.cdb_head = {OPC_READ10, cfg_lun, 5'd0, blk, 8'h00, nblk[15:8]};
                            r.cdb_tail = {nblk[7:0], 8'h00};
                        end else begin
                            if (nblk > 32'hff) begin
                                nblk = 32'hff;
                                sects = {nblk[17:0], 2'b00};
                            end
                            r.cdb_head = {OPC_READ6, cfg_lun, blk[20:16], blk[15:8], blk[7:0],
                                          nblk[7:0], 24'h0};
                        end
                        r.status = ST_ISSUED;
                        r.block_count = nblk[15:0];
                        r.sectors_taken = sects;
                    end
                end
            end
            OP_COMPLETION: begin
                r.status = w.any_error ? ST_FAIL : ST_OK;
                if (!known) begin
                    r.status = (w.any_error || w.driver_error) ? ST_FAIL : ST_OK;
                end else if (w.driver_error) begin
                    drive_tag[d] = '1;
                    if (w.sense_first[6:0] == SENSE_FIXED
                            && w.sense_key_byte[3:0] == KEY_UNIT_ATTN) begin
                        drive_changed[d] = 1'b1;
                        r.status = ST_FAIL;
                    end else if (w.sense_key_byte == KEY_ILLEGAL_REQ) begin
                        r.status = drive_ten_ok[d] ? ST_RETRY : ST_FAIL;
                        drive_ten_ok[d] = 1'b0;
                    end else if (w.sense_key_byte == KEY_NOT_READY) begin
                        r.status = ST_FAIL;
                    end
                end
            end
            OP_QUERY: begin
                r.status = ST_OK;
                if (known) begin
                    if (w.test_failed) begin
                        drive_changed[d] = 1'b1;
                        r.changed_flag = 1'b1;
                    end else begin
                        r.changed_flag = drive_changed[d];
                        if (!w.keep_changed) drive_changed[d] = 1'b0;
                    end
                end
            end
            default: r.status = ST_FAIL;
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            if (mismatches < 100) begin
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            end
            mismatches++;
        end
    endtask

    task automatic compare_reply(input t_out_word want, input t_out_word got);
        check_field("status", want.status, got.status);
        check_field("cdb_is_ten", want.cdb_is_ten, got.cdb_is_ten);
        check_field("cdb_head", want.cdb_head, got.cdb_head);
        check_field("cdb_tail", want.cdb_tail, got.cdb_tail);
        check_field("block_count", want.block_count, got.block_count);
        check_field("sectors_taken", want.sectors_taken, got.sectors_taken);
        check_field("buffer_offset", want.buffer_offset, got.buffer_offset);
        check_field("use_buffer", want.use_buffer, got.use_buffer);
        check_field("changed_flag", want.changed_flag, got.changed_flag);
    endtask

    function automatic int unsigned draw_wait(input int unsigned mode);
        case (mode)
            0: return 0;
            1: return $urandom_range(0, 18);
            default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
        endcase
    endfunction

    // Fields that the operation ignores carry random bits.
    function automatic t_in_word noise_word();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(t_in_word)-1:0];
    endfunction

    function automatic t_in_word req_word(input logic [7:0] dev, input logic wr,
                                          input logic [31:0] sec, input logic [19:0] cnt);
        t_in_word w;
        w = noise_word();
        w.op = OP_REQUEST;
        w.device = dev;
        w.is_write = wr;
        w.sector = sec;
        w.sector_count = cnt;
        if (dev < NUM_DRIVES) recent_sector[dev] = sec;
        return w;
    endfunction

    function automatic t_in_word comp_word(input logic [7:0] dev, input logic any_err,
                                           input logic drv_err, input logic [7:0] s0,
                                           input logic [7:0] s2);
        t_in_word w;
        w = noise_word();
        w.op = OP_COMPLETION;
        w.device = dev;
        w.any_error = any_err;
        w.driver_error = drv_err;
        w.sense_first = s0;
        w.sense_key_byte = s2;
        return w;
    endfunction

    function automatic t_in_word query_word(input logic [7:0] dev, input logic failed,
                                            input logic keep);
        t_in_word w;
        w = noise_word();
        w.op = OP_QUERY;
        w.device = dev;
        w.test_failed = failed;
        w.keep_changed = keep;
        return w;
    endfunction

    function automatic int unsigned pick_drive();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 8 && phase_drives != 0) return $urandom_range(0, phase_drives - 1);
        if (r == 8) return $urandom_range(0, 15);
        return $urandom_range(0, 255);
    endfunction

    function automatic logic [31:0] pick_sector(input int unsigned dev);
        int unsigned r;
        logic [1:0]  offs;
        r = $urandom_range(0, 9);
        offs = 2'($urandom_range(0, 3));
        // Revisiting the last block of a drive is what produces buffer hits.
        if (r < 3 && dev < NUM_DRIVES) return {recent_sector[dev][31:2], offs};
        if (r < 5) return $urandom_range(0, 4095);
        if (r < 7) return 32'h007ffff0 + $urandom_range(0, 31);
        return $urandom;
    endfunction

    function automatic logic [19:0] pick_count();
        int unsigned r;
        logic [31:0] raw;
        r = $urandom_range(0, 19);
        raw = $urandom;
        if (r < 7) return 20'($urandom_range(0, 7));
        if (r < 13) return 20'($urandom_range(0, 1100));
        if (r < 16) return 20'($urandom_range(1016, 1032));
        if (r < 18) return 20'($urandom_range(32'h3fff0, 32'h40010));
        return raw[19:0];
    endfunction

    function automatic logic [7:0] pick_key(input int unsigned dev);
        int unsigned r;
        logic [3:0]  upper;
        r = $urandom_range(0, 9);
        upper = 4'($urandom_range(0, 15));
        if (r < 3) return {upper, KEY_UNIT_ATTN};
        // Illegal request costs a drive its ten-byte mode for good, so this pick spares the low
        // drives to keep READ(10) reachable; the random key below can still draw it.
        if (r < 5) return (dev >= 5) ? KEY_ILLEGAL_REQ : KEY_NOT_READY;
        if (r < 7) return KEY_NOT_READY;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic make_random_word(output t_in_word w);
        int unsigned pick;
        int unsigned dev;
        logic        hi_bit;
        pick = $urandom_range(0, 99);
        dev = pick_drive();
        hi_bit = 1'($urandom_range(0, 1));
        if (pick < 62) begin
            w = req_word(8'(dev), $urandom_range(0, 19) == 0, pick_sector(dev), pick_count());
        end else if (pick < 82) begin
            w = comp_word(8'(dev), 1'($urandom_range(0, 1)), $urandom_range(0, 2) != 0,
                          ($urandom_range(0, 9) < 6) ? {hi_bit, SENSE_FIXED}
                                                     : 8'($urandom_range(0, 255)),
                          pick_key(dev));
        end else if (pick < 97) begin
            w = query_word(8'(dev), $urandom_range(0, 6) == 0, 1'($urandom_range(0, 1)));
        end else begin
            w = noise_word();
            if (pick == 97) w.op = OP_UNDEFINED;
        end
    endtask

    // Drive side: acceptance is seen at the rising edge, new words go out at the falling one.
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) begin
            in_took = 1'b1;
            replies_due.push_back(decide_reply(in_word));
        end
    end

    always @(negedge clk) begin
        if (rst_n) begin
            if (in_took) begin
                in_took = 1'b0;
                feeding = 1'b0;
                send_count++;
                if (send_count % 50 == 0) send_mode = $urandom_range(0, 2);
                send_wait = draw_wait(send_mode);
            end
            if (!feeding) begin
                if (send_wait != 0) begin
                    send_wait--;
                end else if (pending_words.size() != 0) begin
                    in_word <= pending_words.pop_front();
                    feeding = 1'b1;
                end
            end
            in_valid <= feeding;
        end
    end

    // Result side.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            out_took = 1'b1;
            if (replies_due.size() == 0) begin
                if (mismatches < 100) begin
                    $display("%0t: result with nothing expected, got %h", $time, out_word);
                end
                mismatches++;
            end else begin
                compare_reply(replies_due.pop_front(), out_word);
            end
        end
    end

    always @(negedge clk) begin
        if (rst_n) begin
            if (out_took) begin
                out_took = 1'b0;
                results_seen++;
                if (results_seen % 50 == 0) recv_mode = $urandom_range(0, 2);
                recv_wait = draw_wait(recv_mode);
                // A long hold while words are still queued backs the block up.
                if (results_seen >= next_hold && pending_words.size() > 20) begin
                    recv_wait = LONG_HOLD;
                    next_hold += 400;
                end
            end
            if (recv_wait != 0) begin
                recv_wait--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic wait_idle();
        do @(negedge clk);
        while (pending_words.size() != 0 || feeding || replies_due.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [3:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_DEVICE_COUNT) cfg_drives = value;
        else cfg_lun = value[2:0];
    endtask

    task automatic run_phase(input logic [3:0] drives, input logic [2:0] lun,
                             input int unsigned words);
        t_in_word w;
        wait_idle();
        write_reg(CFG_DEVICE_COUNT, drives);
        write_reg(CFG_UNIT_NUMBER, {1'b0, lun});
        phase_drives = (drives > NUM_DRIVES) ? NUM_DRIVES : drives;
        repeat (words) begin
            make_random_word(w);
            pending_words.push_back(w);
        end
    endtask

    initial begin
        for (int i = 0; i < NUM_DRIVES; i++) begin
            drive_tag[i] = '1;
            drive_changed[i] = 1'b0;
            drive_ten_ok[i] = 1'b1;
            recent_sector[i] = 32'd0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_phase(4'd8, 3'd7, 0);
        pending_words.push_back(req_word(8'd0, 1'b0, 32'd0, 20'd4));
        // Offset three at the top sector: one sector, and the block needs READ(10).
        pending_words.push_back(req_word(8'd0, 1'b0, 32'hffffffff, 20'hfffff));
        pending_words.push_back(req_word(8'd0, 1'b0, 32'hffffffff, 20'd1));
        pending_words.push_back(req_word(8'd1, 1'b0, 32'd8, 20'd0));
        pending_words.push_back(req_word(8'd1, 1'b0, 32'd10, 20'hfffff));
        pending_words.push_back(req_word(8'd2, 1'b0, 32'h100, 20'hffffc));
        pending_words.push_back(req_word(8'd2, 1'b0, 32'h104, 20'd2000));
        pending_words.push_back(req_word(8'd2, 1'b0, 32'h7ffffc, 20'd4));
        pending_words.push_back(req_word(8'd2, 1'b0, 32'h800000, 20'd4));
        pending_words.push_back(req_word(8'd3, 1'b1, 32'd0, 20'd4));
        pending_words.push_back(req_word(8'd200, 1'b0, 32'd0, 20'd4));
        pending_words.push_back(comp_word(8'd7, 1'b0, 1'b1, 8'h70, KEY_ILLEGAL_REQ));
        pending_words.push_back(comp_word(8'd7, 1'b1, 1'b1, 8'h00, KEY_ILLEGAL_REQ));
        pending_words.push_back(req_word(8'd7, 1'b0, 32'h200, 20'd2000));
        pending_words.push_back(comp_word(8'd4, 1'b0, 1'b1, 8'hf0, 8'h16));
        pending_words.push_back(req_word(8'd4, 1'b0, 32'd0, 20'd4));
        pending_words.push_back(query_word(8'd4, 1'b0, 1'b1));
        pending_words.push_back(query_word(8'd4, 1'b0, 1'b0));
        pending_words.push_back(query_word(8'd4, 1'b0, 1'b0));
        pending_words.push_back(query_word(8'd5, 1'b1, 1'b0));
        pending_words.push_back(req_word(8'd5, 1'b0, 32'd0, 20'd8));
        pending_words.push_back(query_word(8'd5, 1'b0, 1'b0));
        pending_words.push_back(comp_word(8'd3, 1'b1, 1'b1, 8'h00, KEY_NOT_READY));
        pending_words.push_back(comp_word(8'd3, 1'b1, 1'b0, 8'h70, 8'h06));
        pending_words.push_back(comp_word(8'd3, 1'b0, 1'b1, 8'hff, 8'hff));
        pending_words.push_back(comp_word(8'd255, 1'b0, 1'b1, 8'h70, 8'h06));
        pending_words.push_back(query_word(8'd255, 1'b1, 1'b0));
        begin
            t_in_word odd;
            odd = noise_word();
            odd.op = OP_UNDEFINED;
            pending_words.push_back(odd);
        end

        run_phase(4'd0, 3'd0, 60);
        run_phase(4'd1, 3'd3, 220);
        run_phase(4'd5, 3'd5, 220);
        run_phase(4'd8, 3'd2, 270);
        run_phase(4'd3, 3'd1, 220);
        run_phase(4'd8, 3'd0, 250);
        run_phase(4'd8, 3'd7, 290);

        wait_idle();
        repeat (6) @(negedge clk);
        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("[cdrom_read_command_builder] OK");
        end else begin
            $display("[cdrom_read_command_builder] ERROR");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("[cdrom_read_command_builder] ERROR");
        $finish;
    end

endmodule

/* sim.f */
hdl/cdrcb_pkg.sv
hdl/cdrcb_engine.sv
hdl/cdrom_read_command_builder.sv
sim/tb.sv
